// File: rtl/core/hdtd_pkg.sv
`timescale 1ns / 1ps
// Shared constants and transaction types for the detector hit time decoder.
package hdtd_pkg;

    localparam int BLOCK_HITS  = 4096;
    localparam int FILL_W      = $clog2(BLOCK_HITS + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [63:0] SPAN_LIMIT   = 64'd1099511627776;
    localparam logic [63:0] T1_WRAP_STEP = 64'h0000_0000_0001_0000;
    localparam logic [63:0] FINE_STEP    = 64'd1024;
    localparam logic [63:0] PREV_STEP    = 64'd4096;

    localparam int HIT_TYPE_BIT = 23;

    localparam logic [4:0] ELINK_A_FIRST = 5'd9;
    localparam logic [4:0] ELINK_A_LAST  = 5'd14;
    localparam logic [4:0] ELINK_B_FIRST = 5'd15;
    localparam logic [4:0] ELINK_B_LAST  = 5'd20;

    typedef struct packed {
        logic [7:0]  link_number;
        logic [4:0]  elink_number;
        logic [31:0] recv_timetag;
        logic [63:0] event_low;
        logic [23:0] event_high;
    } hdtd_in_t;

    typedef struct packed {
        logic [19:0]        channel_id;
        logic [2:0]         tac_id;
        logic [9:0]         t1_fine;
        logic [9:0]         t2_fine;
        logic [9:0]         q_fine;
        logic [3:0]         prev_flags;
        logic signed [63:0] hit_time;
        logic signed [63:0] end_time;
        logic signed [63:0] charge_end_time;
        logic signed [63:0] previous_event_time;
        logic               block_start;
    } hdtd_out_t;

    // Decoded fields of one kept hit, including the coarse time fields.
    typedef struct packed {
        logic [19:0] channel_id;
        logic [2:0]  tac_id;
        logic [9:0]  t1_fine;
        logic [9:0]  t2_fine;
        logic [9:0]  q_fine;
        logic [3:0]  prev_flags;
        logic [13:0] t1_coarse;
        logic [9:0]  t2_coarse;
        logic [9:0]  q_coarse;
        logic [9:0]  prev_coarse;
    } hdtd_hit_t;

    typedef struct packed {
        hdtd_hit_t   hit;
        logic [63:0] rx_time;
    } hdtd_entry_t;

endpackage

// File: rtl/core/hdtd_front.sv
`timescale 1ns / 1ps
// Front end: filters hits, tracks the reference link and timetag wraps, unwraps the timetag.
module hdtd_front import hdtd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  hdtd_in_t    s_data,
    output logic        q_valid,
    input  logic        q_ready,
    output hdtd_entry_t q_data
);

    logic        ref_seen_reg;
    logic [12:0] ref_lid_reg;
    logic [31:0] ref_tt_reg;
    logic [31:0] prev_tt_reg;
    logic [31:0] wrap_reg;

    logic        ref_seen_next;
    logic [12:0] ref_lid_next;
    logic [31:0] ref_tt_next;
    logic [31:0] prev_tt_next;
    logic [31:0] wrap_next;

    logic        f1_valid_reg;
    hdtd_hit_t   f1_hit_reg;
    logic [31:0] f1_tt_reg;
    logic [31:0] f1_wrap_reg;
    logic [31:0] f1_ref_reg;

    logic        f2_valid_reg;
    hdtd_entry_t f2_entry_reg;

    logic        keep;
    logic [2:0]  mapped;
    logic [12:0] lid;
    logic        take;
    logic        f1_ready;
    logic        f2_ready;
    hdtd_hit_t   hit;

    always_comb begin
        keep   = 1'b0;
        mapped = '0;
        if (s_data.elink_number inside {[ELINK_A_FIRST:ELINK_A_LAST]}) begin
            keep   = 1'b1;
            mapped = 3'(ELINK_A_LAST - s_data.elink_number);
        end else if (s_data.elink_number inside {[ELINK_B_FIRST:ELINK_B_LAST]}) begin
            keep   = 1'b1;
            mapped = 3'(ELINK_B_LAST - s_data.elink_number);
        end
        if (s_data.event_high[HIT_TYPE_BIT]) begin
            keep = 1'b0;
        end
    end

    always_comb begin
        hit.channel_id  = {s_data.link_number, 3'b000, mapped, 1'b0, s_data.event_low[4:0]};
        hit.tac_id      = s_data.event_low[7:5];
        hit.t1_fine     = s_data.event_low[32:23];
        hit.t2_fine     = s_data.event_low[42:33];
        hit.q_fine      = s_data.event_low[52:43];
        hit.prev_flags  = s_data.event_low[11:8];
        hit.t1_coarse   = s_data.event_high[22:9];
        hit.t2_coarse   = {s_data.event_high[8:0], s_data.event_low[63]};
        hit.q_coarse    = s_data.event_low[62:53];
        hit.prev_coarse = s_data.event_low[22:13];
    end

    assign lid      = {s_data.link_number, s_data.elink_number};
    assign f2_ready = !f2_valid_reg || q_ready;
    assign f1_ready = !f1_valid_reg || f2_ready;
    assign s_ready  = f1_ready;
    assign take     = s_valid && s_ready && keep;

    // The first kept hit sets the reference; later hits on that link and elink count falling bit 31.
    always_comb begin
        ref_seen_next = ref_seen_reg;
        ref_lid_next  = ref_lid_reg;
        ref_tt_next   = ref_tt_reg;
        prev_tt_next  = prev_tt_reg;
        wrap_next     = wrap_reg;
        if (!ref_seen_reg) begin
            ref_seen_next = 1'b1;
            ref_lid_next  = lid;
            ref_tt_next   = s_data.recv_timetag;
            prev_tt_next  = s_data.recv_timetag;
            wrap_next     = '0;
        end else if (lid == ref_lid_reg) begin
            if (prev_tt_reg[31] && !s_data.recv_timetag[31]) begin
                wrap_next = wrap_reg + 32'd1;
            end
            prev_tt_next = s_data.recv_timetag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_seen_reg <= 1'b0;
            ref_lid_reg  <= '0;
            ref_tt_reg   <= '0;
            prev_tt_reg  <= '0;
            wrap_reg     <= '0;
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                ref_seen_reg <= ref_seen_next;
                ref_lid_reg  <= ref_lid_next;
                ref_tt_reg   <= ref_tt_next;
                prev_tt_reg  <= prev_tt_next;
                wrap_reg     <= wrap_next;
            end
            if (f1_ready) begin
                f1_valid_reg <= s_valid && keep;
            end
            if (f2_ready) begin
                f2_valid_reg <= f1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            f1_hit_reg  <= hit;
            f1_tt_reg   <= s_data.recv_timetag;
            f1_wrap_reg <= wrap_next;
            f1_ref_reg  <= ref_tt_next;
        end
        if (f2_ready && f1_valid_reg) begin
            f2_entry_reg.hit     <= f1_hit_reg;
            f2_entry_reg.rx_time <= {f1_wrap_reg, f1_tt_reg} - {32'd0, f1_ref_reg};
        end
    end

    assign q_valid = f2_valid_reg;
    assign q_data  = f2_entry_reg;

endmodule

// File: rtl/core/hdtd_queue.sv
`timescale 1ns / 1ps
// Short FIFO that decouples the front end from the time reconstruction back end.
module hdtd_queue import hdtd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push_valid,
    output logic        push_ready,
    input  hdtd_entry_t push_data,
    output logic        pop_valid,
    input  logic        pop_ready,
    output hdtd_entry_t pop_data
);

    hdtd_entry_t            mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   push;
    logic                   pop;

    assign push_ready = count_reg != QUEUE_CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                              : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                              : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/core/hdtd_back.sv
`timescale 1ns / 1ps
// Back end: coarse time corrections, output block tracking and block-relative times.
module hdtd_back import hdtd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  hdtd_entry_t q_data,
    output logic        m_valid,
    input  logic        m_ready,
    output hdtd_out_t   m_data
);

    // Stage 1: absolute T1.
    logic        b1_valid_reg;
    hdtd_hit_t   b1_hit_reg;
    logic [63:0] b1_abs1_reg;
    logic [63:0] abs1_base;
    logic [63:0] abs1_next;

    // Stage 2: block tracking and T2, Q, previous-event corrections.
    logic        b2_valid_reg;
    hdtd_hit_t   b2_hit_reg;
    logic [63:0] b2_t1_reg;
    logic [63:0] b2_t2_reg;
    logic [63:0] b2_tq_reg;
    logic [63:0] b2_tp_reg;
    logic [63:0] b2_min_reg;
    logic        b2_bstart_reg;

    // Stage 3: output register.
    logic        b3_valid_reg;
    hdtd_out_t   b3_data_reg;
    hdtd_out_t   out_next;

    // Block state; span_reg always holds block max minus block min.
    logic [63:0]       block_max_reg;
    logic [63:0]       block_min_reg;
    logic [63:0]       span_reg;
    logic [FILL_W-1:0] block_fill_reg;

    logic [63:0]       block_max_next;
    logic [63:0]       block_min_next;
    logic [63:0]       span_next;
    logic [FILL_W-1:0] block_fill_next;
    logic              above_max;
    logic              bstart_next;

    logic [63:0] t1_next;
    logic [63:0] t2_base;
    logic [63:0] tq_base;
    logic [63:0] tp_base;
    logic [63:0] t2_next;
    logic [63:0] tq_next;
    logic [63:0] tp_next;

    logic b1_ready;
    logic b2_ready;
    logic b3_ready;
    logic b1_load;
    logic b2_load;
    logic b3_load;

    assign b3_ready = !b3_valid_reg || m_ready;
    assign b2_ready = !b2_valid_reg || b3_ready;
    assign b1_ready = !b1_valid_reg || b2_ready;
    assign q_ready  = b1_ready;
    assign b1_load  = q_valid && b1_ready;
    assign b2_load  = b1_valid_reg && b2_ready;
    assign b3_load  = b2_valid_reg && b3_ready;

    // The 14-bit coarse field overlaps the base at bit 13 on purpose.
    always_comb begin
        abs1_base = {q_data.rx_time[63:13], 13'd0} | {50'd0, q_data.hit.t1_coarse};
        abs1_next = abs1_base;
        if ($signed(abs1_base) < $signed(q_data.rx_time)) begin
            abs1_next = abs1_base + T1_WRAP_STEP;
        end
    end

    always_comb begin
        above_max      = b1_abs1_reg > block_max_reg;
        block_max_next = above_max ? b1_abs1_reg : block_max_reg;
        span_next      = above_max ? (b1_abs1_reg - block_min_reg) : span_reg;
        bstart_next    = (block_fill_reg >= FILL_W'(BLOCK_HITS)) || (span_next > SPAN_LIMIT);
        if (bstart_next) begin
            block_min_next  = block_max_next;
            block_fill_next = FILL_W'(1);
            span_next       = '0;
        end else begin
            block_min_next  = block_min_reg;
            block_fill_next = block_fill_reg + 1'b1;
        end
    end

    always_comb begin
        t1_next = {b1_abs1_reg[63:10], 10'd0} | {50'd0, b1_hit_reg.t1_coarse};
        t2_base = {1'b0, t1_next[62:10], b1_hit_reg.t2_coarse};
        tq_base = {1'b0, t1_next[62:10], b1_hit_reg.q_coarse};
        tp_base = {1'b0, t1_next[62:12], b1_hit_reg.prev_coarse, 2'b00};
        t2_next = ($signed(t2_base) < $signed(t1_next)) ? t2_base + FINE_STEP : t2_base;
        tq_next = ($signed(tq_base) < $signed(t1_next)) ? tq_base + FINE_STEP : tq_base;
        tp_next = ($signed(tp_base) < $signed(t1_next)) ? tp_base : tp_base - PREV_STEP;
    end

    always_comb begin
        out_next.channel_id          = b2_hit_reg.channel_id;
        out_next.tac_id              = b2_hit_reg.tac_id;
        out_next.t1_fine             = b2_hit_reg.t1_fine;
        out_next.t2_fine             = b2_hit_reg.t2_fine;
        out_next.q_fine              = b2_hit_reg.q_fine;
        out_next.prev_flags          = b2_hit_reg.prev_flags;
        out_next.hit_time            = b2_t1_reg - b2_min_reg;
        out_next.end_time            = b2_t2_reg - b2_min_reg;
        out_next.charge_end_time     = b2_tq_reg - b2_min_reg;
        out_next.previous_event_time = b2_tp_reg - b2_min_reg;
        out_next.block_start         = b2_bstart_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg   <= 1'b0;
            b2_valid_reg   <= 1'b0;
            b3_valid_reg   <= 1'b0;
            block_max_reg  <= '0;
            block_min_reg  <= '0;
            span_reg       <= '0;
            block_fill_reg <= '0;
        end else begin
            if (b1_ready) begin
                b1_valid_reg <= q_valid;
            end
            if (b2_ready) begin
                b2_valid_reg <= b1_valid_reg;
            end
            if (b3_ready) begin
                b3_valid_reg <= b2_valid_reg;
            end
            if (b2_load) begin
                block_max_reg  <= block_max_next;
                block_min_reg  <= block_min_next;
                span_reg       <= span_next;
                block_fill_reg <= block_fill_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b1_load) begin
            b1_hit_reg  <= q_data.hit;
            b1_abs1_reg <= abs1_next;
        end
        if (b2_load) begin
            b2_hit_reg    <= b1_hit_reg;
            b2_t1_reg     <= t1_next;
            b2_t2_reg     <= t2_next;
            b2_tq_reg     <= tq_next;
            b2_tp_reg     <= tp_next;
            b2_min_reg    <= block_min_next;
            b2_bstart_reg <= bstart_next;
        end
        if (b3_load) begin
            b3_data_reg <= out_next;
        end
    end

    assign m_valid = b3_valid_reg;
    assign m_data  = b3_data_reg;

    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        block_fill_reg <= FILL_W'(BLOCK_HITS))
        else $error("block fill count beyond block size");

    a_start_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        b2_load && bstart_next |=> block_fill_reg == FILL_W'(1))
        else $error("new block does not start with one hit");

    a_start_span: assert property (@(posedge aclk) disable iff (!aresetn)
        b2_load && bstart_next |=> span_reg == '0 && block_min_reg == block_max_reg)
        else $error("new block does not start with zero span");

    a_min_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !b2_load |=> $stable(block_min_reg) && $stable(block_fill_reg))
        else $error("block state changed without a transaction");

endmodule

// File: rtl/core/detector_hit_time_decoder_unit.sv
`timescale 1ns / 1ps
// Detector hit time decoder top level: front end, decoupling queue and back end.
// Throughput: one hit per cycle on both channels, sustained while m_ready is high.
// Path: a kept hit passes two front stages, the queue, then three back stages
// (the last is the output register) before its result is offered on m_valid.
// Dropped hits produce no result and leave all state untouched.
// Reset (aresetn low, synchronous) clears the reference, wrap count, block state and queue.
module detector_hit_time_decoder_unit import hdtd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  hdtd_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output hdtd_out_t m_data
);

    logic        fq_valid;
    logic        fq_ready;
    hdtd_entry_t fq_data;
    logic        qb_valid;
    logic        qb_ready;
    hdtd_entry_t qb_data;

    hdtd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_data  (fq_data)
    );

    hdtd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    hdtd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_data  (qb_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: tb/hdtd_hit_checker.sv
`timescale 1ns / 1ps
// Hit time decoder checker: predicts each kept hit's result and compares it with the output.
module hdtd_hit_checker import hdtd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  hdtd_in_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  hdtd_out_t m_data,
    output int        fail_count,
    output int        pending_count
);

    localparam logic [2:0] ELINK_UNKNOWN = 3'd6;

    hdtd_out_t   pending_hit_results[$];

    logic        ref_seen;
    logic [15:0] ref_link_id;
    logic [31:0] ref_timetag;
    logic [31:0] last_ref_timetag;
    logic [31:0] timetag_wraps;
    logic [63:0] block_min;
    logic [63:0] block_max;
    int          block_fill;

    initial begin
        fail_count = 0;
        pending_count = 0;
    end

    function automatic logic [2:0] elink_slot(input logic [4:0] elink);
        if (elink >= ELINK_A_FIRST && elink <= ELINK_A_LAST) begin
            return 3'(ELINK_A_LAST - elink);
        end else if (elink >= ELINK_B_FIRST && elink <= ELINK_B_LAST) begin
            return 3'(ELINK_B_LAST - elink);
        end
        return ELINK_UNKNOWN;
    endfunction

    function automatic void clear_timebase();
        ref_seen = 1'b0;
        ref_link_id = '0;
        ref_timetag = '0;
        last_ref_timetag = '0;
        timetag_wraps = '0;
        block_min = '0;
        block_max = '0;
        block_fill = 0;
    endfunction

    // Rebuilds the absolute times of one hit and queues the result it should produce.
    function automatic void decode_hit_times(input hdtd_in_t h);
        logic [2:0]  slot;
        logic [15:0] link_id;
        logic [63:0] rx_time, t1_abs, t1, t2, tq, tp;
        logic [13:0] t1_coarse;
        logic [9:0]  t2_coarse, q_coarse, prev_coarse;
        logic        opens_block;
        hdtd_out_t   r;

        slot = elink_slot(h.elink_number);
        if (h.event_high[HIT_TYPE_BIT] || slot == ELINK_UNKNOWN) return;

        link_id = {h.link_number, 3'b000, h.elink_number};
        if (!ref_seen) begin
            ref_seen = 1'b1;
            ref_link_id = link_id;
            ref_timetag = h.recv_timetag;
            last_ref_timetag = h.recv_timetag;
            timetag_wraps = '0;
        end else if (link_id == ref_link_id) begin
            if (last_ref_timetag[31] && !h.recv_timetag[31]) begin
                timetag_wraps = timetag_wraps + 32'd1;
            end
            last_ref_timetag = h.recv_timetag;
        end

        rx_time = {32'd0, h.recv_timetag} + {timetag_wraps, 32'd0} - {32'd0, ref_timetag};

        t1_coarse = h.event_high[22:9];
        t2_coarse = {h.event_high[8:0], h.event_low[63]};
        q_coarse = h.event_low[62:53];
        prev_coarse = h.event_low[22:13];

        // The coarse T1 field is 14 bits wide but only 13 base bits are cleared.
        t1_abs = {rx_time[63:13], 13'd0} | {50'd0, t1_coarse};
        if ($signed(t1_abs) < $signed(rx_time)) t1_abs = t1_abs + T1_WRAP_STEP;

        if (t1_abs > block_max) block_max = t1_abs;
        opens_block = 1'b0;
        if (block_fill + 1 > BLOCK_HITS || (block_max - block_min) > SPAN_LIMIT) begin
            block_min = block_max;
            block_fill = 0;
            opens_block = 1'b1;
        end
        block_fill = block_fill + 1;

        t1 = {t1_abs[63:10], 10'd0} | {50'd0, t1_coarse};
        t2 = {1'b0, t1[62:10], t2_coarse};
        tq = {1'b0, t1[62:10], q_coarse};
        tp = {1'b0, t1[62:12], prev_coarse, 2'b00};
        if ($signed(t2) < $signed(t1)) t2 = t2 + FINE_STEP;
        if ($signed(tq) < $signed(t1)) tq = tq + FINE_STEP;
        if (!($signed(tp) < $signed(t1))) tp = tp - PREV_STEP;

        r.channel_id = {h.link_number, 3'b000, slot, 1'b0, h.event_low[4:0]};
        r.tac_id = h.event_low[7:5];
        r.t1_fine = h.event_low[32:23];
        r.t2_fine = h.event_low[42:33];
        r.q_fine = h.event_low[52:43];
        r.prev_flags = h.event_low[11:8];
        r.hit_time = t1 - block_min;
        r.end_time = t2 - block_min;
        r.charge_end_time = tq - block_min;
        r.previous_event_time = tp - block_min;
        r.block_start = opens_block;
        pending_hit_results.push_back(r);
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $realtime, name, want, got);
            fail_count = fail_count + 1;
        end
    endfunction

    function automatic void check_hit_result(input hdtd_out_t got);
        hdtd_out_t want;

        if (pending_hit_results.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h", $realtime, got);
            fail_count = fail_count + 1;
            return;
        end
        want = pending_hit_results.pop_front();
        check_field("channel_id", 64'(want.channel_id), 64'(got.channel_id));
        check_field("tac_id", 64'(want.tac_id), 64'(got.tac_id));
        check_field("t1_fine", 64'(want.t1_fine), 64'(got.t1_fine));
        check_field("t2_fine", 64'(want.t2_fine), 64'(got.t2_fine));
        check_field("q_fine", 64'(want.q_fine), 64'(got.q_fine));
        check_field("prev_flags", 64'(want.prev_flags), 64'(got.prev_flags));
        check_field("hit_time", want.hit_time, got.hit_time);
        check_field("end_time", want.end_time, got.end_time);
        check_field("charge_end_time", want.charge_end_time, got.charge_end_time);
        check_field("previous_event_time", want.previous_event_time, got.previous_event_time);
        check_field("block_start", 64'(want.block_start), 64'(got.block_start));
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_timebase();
            pending_hit_results.delete();
        end else begin
            // A result accepted now always belongs to an earlier hit, so check before predicting.
            if (m_valid && m_ready) check_hit_result(m_data);
            if (s_valid && s_ready) decode_hit_times(s_data);
        end
        pending_count = pending_hit_results.size();
    end

endmodule

// File: tb/detector_hit_time_decoder_unit_test.sv
`timescale 1ns / 1ps
// Testbench top for the hit time decoder: clock, reset, hit stimulus, output stalls and verdict.
module detector_hit_time_decoder_unit_test;
    import hdtd_pkg::*;

    localparam logic [7:0]  REF_LINK       = 8'h5A;
    localparam logic [4:0]  REF_ELINK      = 5'd12;
    localparam logic [31:0] REF_TIMETAG    = 32'h4000_0000;
    localparam int          RANDOM_HITS    = 1500;
    localparam int          FILL_RUN_HITS  = 380;
    localparam int          DRAIN_CYCLES   = 20;
    localparam int unsigned TIMEOUT_CYCLES = 800000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    hdtd_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    hdtd_out_t m_data;

    int          fail_count;
    int          pending_count;
    int unsigned cycle_count = 0;
    int          burst_left = 0;
    logic [31:0] ref_stream_tt = REF_TIMETAG;
    logic [15:0] ready_pattern = 16'hFFFF;
    int          pattern_left = 0;

    detector_hit_time_decoder_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    hdtd_hit_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // The output side rotates a stall pattern that is replaced after a random number of cycles.
    always @(negedge aclk) begin
        if (pattern_left == 0) begin
            pattern_left <= $urandom_range(16, 400);
            case ($urandom_range(0, 3))
                0: ready_pattern <= 16'hFFFF;
                1: ready_pattern <= 16'($urandom) | 16'h0101;
                2: ready_pattern <= 16'h0001 << $urandom_range(0, 15);
                default: ready_pattern <= 16'h5555;
            endcase
        end else begin
            pattern_left <= pattern_left - 1;
            ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
        end
        m_ready <= ready_pattern[0];
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic hdtd_in_t hit_of(input logic [7:0] link, input logic [4:0] elink,
                                        input logic [31:0] tt, input logic [63:0] lo,
                                        input logic [23:0] hi);
        hdtd_in_t h;
        h.link_number = link;
        h.elink_number = elink;
        h.recv_timetag = tt;
        h.event_low = lo;
        h.event_high = hi;
        return h;
    endfunction

    function automatic logic [23:0] clean_high();
        logic [23:0] hi;
        hi = 24'($urandom);
        hi[HIT_TYPE_BIT] = 1'b0;
        return hi;
    endfunction

    // Well-formed hit: mostly the reference link with a steadily advancing timetag.
    function automatic hdtd_in_t stream_hit();
        hdtd_in_t    h;
        int unsigned pick;

        pick = $urandom_range(0, 99);
        h = hit_of(8'($urandom), 5'($urandom_range(9, 20)), $urandom, rand64(), clean_high());
        if (pick < 50) begin
            ref_stream_tt = ref_stream_tt + $urandom_range(0, 32'h2000_0000);
            h.link_number = REF_LINK;
            h.elink_number = REF_ELINK;
            h.recv_timetag = ref_stream_tt;
        end else if (pick < 60) begin
            // Same link on another elink: its timetag falls must not count as wraps.
            h.link_number = REF_LINK;
            if (h.elink_number == REF_ELINK) h.elink_number = REF_ELINK + 5'd1;
        end else if (pick < 85) begin
            h.recv_timetag = ref_stream_tt + $urandom_range(0, 32'h1_0000) - 32'h8000;
        end
        return h;
    endfunction

    function automatic hdtd_in_t mixed_hit();
        hdtd_in_t    h;
        int unsigned pick;

        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            h = stream_hit();
        end else if (pick < 88) begin
            h = hit_of(8'($urandom), 5'($urandom), $urandom, rand64(), 24'($urandom));
        end else begin
            h = stream_hit();
            if (pick < 94) begin
                h.event_high[HIT_TYPE_BIT] = 1'b1;
            end else if ($urandom_range(0, 1) == 0) begin
                h.elink_number = 5'($urandom_range(0, 8));
            end else begin
                h.elink_number = 5'($urandom_range(21, 31));
            end
        end
        return h;
    endfunction

    // Offers one hit and returns at the falling edge after it has been accepted.
    task automatic send_hit(input hdtd_in_t h);
        int gap;

        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data <= h;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        burst_left = burst_left - 1;
    endtask

    task automatic send_random_hits(input int hit_count);
        for (int i = 0; i < hit_count; i++) begin
            send_hit(mixed_hit());
        end
    endtask

    initial begin
        hdtd_in_t h;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Dropped hits before any reference exists must not set one.
        send_hit(hit_of(REF_LINK, REF_ELINK, 32'h1234, rand64(), 24'h80_0000 | 24'($urandom)));
        send_hit(hit_of(REF_LINK, 5'd8, 32'h1234, rand64(), clean_high()));
        send_hit(hit_of(REF_LINK, 5'd21, 32'h1234, rand64(), clean_high()));
        send_hit(hit_of(8'h00, 5'd0, 32'h0, rand64(), clean_high()));
        send_hit(hit_of(8'hFF, 5'd31, 32'hFFFF_FFFF, rand64(), clean_high()));

        // First kept hit fixes the reference, then the event word extremes.
        send_hit(hit_of(REF_LINK, REF_ELINK, REF_TIMETAG, 64'h0, 24'h0));
        send_hit(hit_of(REF_LINK, REF_ELINK, REF_TIMETAG + 32'h100, '1, 24'h7F_FFFF));

        // Elink range boundaries on extreme links.
        send_hit(hit_of(8'h00, 5'd9, REF_TIMETAG, rand64(), clean_high()));
        send_hit(hit_of(8'hFF, 5'd14, REF_TIMETAG, rand64(), clean_high()));
        send_hit(hit_of(8'h80, 5'd15, REF_TIMETAG, rand64(), clean_high()));
        send_hit(hit_of(8'h01, 5'd20, 32'hFFFF_FFFF, rand64(), clean_high()));

        // A timetag before the reference gives negative times.
        send_hit(hit_of(REF_LINK, REF_ELINK, 32'h0000_0010, rand64(), clean_high()));

        // Bit 31 falls on the reference link: one wrap.
        send_hit(hit_of(REF_LINK, REF_ELINK, 32'hFFFF_FFF0, rand64(), clean_high()));
        send_hit(hit_of(REF_LINK, REF_ELINK, 32'h0000_0005, rand64(), clean_high()));

        // Same link, other elink: a falling bit 31 is not a wrap.
        send_hit(hit_of(REF_LINK, 5'd13, 32'h8000_0000, rand64(), clean_high()));
        send_hit(hit_of(REF_LINK, 5'd13, 32'h0000_0000, rand64(), clean_high()));

        // Coarse T1 values whose bit 13 overlaps the base, and one below the base.
        send_hit(hit_of(REF_LINK, REF_ELINK, REF_TIMETAG + 32'h3000, rand64(),
                        {1'b0, 14'h2000, 9'($urandom)}));
        send_hit(hit_of(REF_LINK, REF_ELINK, REF_TIMETAG + 32'h3000, rand64(),
                        {1'b0, 14'h3FFF, 9'($urandom)}));
        send_hit(hit_of(REF_LINK, REF_ELINK, REF_TIMETAG + 32'h1FFF, rand64(),
                        {1'b0, 14'h0000, 9'($urandom)}));
        send_hit(hit_of(REF_LINK, REF_ELINK, REF_TIMETAG + 32'h1FFF, rand64(),
                        {1'b0, 14'h1FFF, 9'($urandom)}));

        ref_stream_tt = REF_TIMETAG;
        send_random_hits(RANDOM_HITS / 2);

        // A run of close timetags on the reference link keeps adding hits to one block.
        for (int i = 0; i < FILL_RUN_HITS; i++) begin
            ref_stream_tt = ref_stream_tt + $urandom_range(0, 255);
            h = hit_of(REF_LINK, REF_ELINK, ref_stream_tt, rand64(), clean_high());
            send_hit(h);
        end

        send_random_hits(RANDOM_HITS - RANDOM_HITS / 2);

        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/hdtd_pkg.sv
rtl/core/hdtd_front.sv
rtl/core/hdtd_queue.sv
rtl/core/hdtd_back.sv
rtl/core/detector_hit_time_decoder_unit.sv
tb/hdtd_hit_checker.sv
tb/detector_hit_time_decoder_unit_test.sv
